>>> hdl/yvs_pkg.sv
// Shared types and constants for the YUYV to RGB565 converter with vertical scaler.
// Holds the chroma coefficients, the chroma term bundle and the per-word control flags.
// No dependencies.
package yvs_pkg;

   localparam int CFG_W   = 12;
   localparam int CSR_IDX_W = 2;
   localparam int TERM_W  = 10;
   localparam int PROD_W  = 20;
   localparam int FRAC_W  = 10;

   localparam logic [CSR_IDX_W-1:0] REG_LINE_PIXELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_LINES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_LINES   = 2'd2;

   localparam logic [CFG_W-1:0] RESET_LINE_PIXELS = 12'd800;
   localparam logic [CFG_W-1:0] RESET_SRC_LINES   = 12'd600;
   localparam logic [CFG_W-1:0] RESET_DST_LINES   = 12'd480;

   localparam logic signed [11:0] COEF_RV = 12'sd1436;
   localparam logic signed [11:0] COEF_GU = 12'sd352;
   localparam logic signed [11:0] COEF_GV = 12'sd731;
   localparam logic signed [11:0] COEF_BU = 12'sd1813;

   localparam logic signed [8:0] CHROMA_BIAS = 9'sd128;
   localparam logic signed [10:0] CHAN_MAX   = 11'sd255;

   typedef struct packed {
      logic signed [TERM_W-1:0] rv;
      logic signed [TERM_W-1:0] gu;
      logic signed [TERM_W-1:0] gv;
      logic signed [TERM_W-1:0] bu;
   } chroma_terms_type;

   typedef struct packed {
      logic kept;
      logic second_valid;
      logic line_last;
      logic frame_last;
   } row_ctrl_type;

endpackage

>>> hdl/yvs_chroma.sv
// Chroma front end: removes the 128 offset from U and V and forms the four
// fixed-point chroma terms shared by both pixel lanes. Depends on yvs_pkg.
module yvs_chroma (
   input  logic [7:0]                 chroma_blue,
   input  logic [7:0]                 chroma_red,
   output yvs_pkg::chroma_terms_type  terms
);
   import yvs_pkg::*;

   logic signed [8:0]        cu;
   logic signed [8:0]        cv;
   logic signed [PROD_W-1:0] p_rv;
   logic signed [PROD_W-1:0] p_gu;
   logic signed [PROD_W-1:0] p_gv;
   logic signed [PROD_W-1:0] p_bu;

   assign cu = $signed({1'b0, chroma_blue}) - CHROMA_BIAS;
   assign cv = $signed({1'b0, chroma_red}) - CHROMA_BIAS;

   assign p_rv = PROD_W'(cv) * PROD_W'(COEF_RV);
   assign p_gu = PROD_W'(cu) * PROD_W'(COEF_GU);
   assign p_gv = PROD_W'(cv) * PROD_W'(COEF_GV);
   assign p_bu = PROD_W'(cu) * PROD_W'(COEF_BU);

   // Taking the upper bits of a two's complement product is a floor division by 1024.
   assign terms.rv = $signed(p_rv[PROD_W-1:FRAC_W]);
   assign terms.gu = $signed(p_gu[PROD_W-1:FRAC_W]);
   assign terms.gv = $signed(p_gv[PROD_W-1:FRAC_W]);
   assign terms.bu = $signed(p_bu[PROD_W-1:FRAC_W]);

endmodule

>>> hdl/yvs_pixel_lane.sv
// One pixel lane: adds the chroma terms to a luma sample, clamps each channel
// to 0..255 and packs RGB565. Depends on yvs_pkg.
module yvs_pixel_lane (
   input  logic [7:0]                luma,
   input  yvs_pkg::chroma_terms_type terms,
   output logic [15:0]               rgb
);
   import yvs_pkg::*;

   logic signed [10:0] y_s;
   logic signed [10:0] r_s;
   logic signed [10:0] g_s;
   logic signed [10:0] b_s;
   logic [7:0]         r8;
   logic [7:0]         g8;
   logic [7:0]         b8;

   function automatic logic [7:0] clamp8(input logic signed [10:0] v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > CHAN_MAX) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   assign y_s = $signed({3'b000, luma});
   assign r_s = y_s + 11'(terms.rv);
   assign g_s = y_s - 11'(terms.gu) - 11'(terms.gv);
   assign b_s = y_s + 11'(terms.bu);

   assign r8 = clamp8(r_s);
   assign g8 = clamp8(g_s);
   assign b8 = clamp8(b_s);

   assign rgb = {r8[7:3], g8[7:2], b8[7:3]};

endmodule

>>> hdl/yvs_row_ctrl.sv
// Raster position tracking, configuration registers and the vertical
// nearest-neighbour row selection. Depends on yvs_pkg.
module yvs_row_ctrl #(
   parameter int MAX_LINE_PIXELS = 2048,
   parameter int MAX_LINES       = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [yvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [yvs_pkg::CFG_W-1:0]      csr_data,
   input  logic                           advance,
   output yvs_pkg::row_ctrl_type          ctrl
);
   import yvs_pkg::*;

   localparam int PW = $clog2(MAX_LINE_PIXELS + 1);
   localparam int LW = $clog2(MAX_LINES + 1);
   localparam int AW = 2 * LW + 1;

   logic [CFG_W-1:0] line_pixels_ff;
   logic [CFG_W-1:0] src_lines_ff;
   logic [CFG_W-1:0] dst_lines_ff;

   logic [PW-1:0] column_ff, column_in;
   logic [LW-1:0] src_row_ff, src_row_in;
   logic [LW-1:0] out_row_ff, out_row_in;
   // acc_ff tracks out_row * src, brd_ff tracks src_row * dst.
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] brd_ff, brd_in;

   logic [PW-1:0] width_eff;
   logic [PW-1:0] items;
   logic [LW-1:0] src_eff;
   logic [LW-1:0] dst_clamped;
   logic [LW-1:0] dst_eff;
   logic          at_end;
   logic          row_kept;
   logic          src_wrap;

   function automatic logic [PW-1:0] eff_pixels(input logic [CFG_W-1:0] v);
      logic [PW-1:0] res;
      if (v == '0) begin
         res = PW'(1);
      end else if (int'(v) > MAX_LINE_PIXELS) begin
         res = PW'(MAX_LINE_PIXELS);
      end else begin
         res = PW'(v);
      end
      return res;
   endfunction

   function automatic logic [LW-1:0] eff_lines(input logic [CFG_W-1:0] v);
      logic [LW-1:0] res;
      if (v == '0) begin
         res = LW'(1);
      end else if (int'(v) > MAX_LINES) begin
         res = LW'(MAX_LINES);
      end else begin
         res = LW'(v);
      end
      return res;
   endfunction

   assign width_eff   = eff_pixels(line_pixels_ff);
   assign items       = PW'(({1'b0, width_eff} + (PW+1)'(1)) >> 1);
   assign src_eff     = eff_lines(src_lines_ff);
   assign dst_clamped = eff_lines(dst_lines_ff);
   assign dst_eff     = (dst_clamped > src_eff) ? src_eff : dst_clamped;

   assign at_end   = ({1'b0, column_ff} + (PW+1)'(1)) >= {1'b0, items};
   // The current source row is the one the next output row maps to exactly when
   // out_row * src still falls below (src_row + 1) * dst.
   assign row_kept = (out_row_ff < dst_eff) && (acc_ff < brd_ff + AW'(dst_eff));
   assign src_wrap = ({1'b0, src_row_ff} + (LW+1)'(1)) >= {1'b0, src_eff};

   assign ctrl.kept         = row_kept;
   assign ctrl.second_valid = !(width_eff[0] && at_end);
   assign ctrl.line_last    = at_end;
   assign ctrl.frame_last   = at_end &&
                              (({1'b0, out_row_ff} + (LW+1)'(1)) == {1'b0, dst_eff});

   always_comb begin
      column_in  = column_ff;
      src_row_in = src_row_ff;
      out_row_in = out_row_ff;
      acc_in     = acc_ff;
      brd_in     = brd_ff;
      if (csr_valid) begin
         column_in  = '0;
         src_row_in = '0;
         out_row_in = '0;
         acc_in     = '0;
         brd_in     = '0;
      end else if (advance) begin
         if (at_end) begin
            column_in = '0;
            if (src_wrap) begin
               src_row_in = '0;
               out_row_in = '0;
               acc_in     = '0;
               brd_in     = '0;
            end else begin
               src_row_in = src_row_ff + LW'(1);
               brd_in     = brd_ff + AW'(dst_eff);
               if (row_kept) begin
                  out_row_in = out_row_ff + LW'(1);
                  acc_in     = acc_ff + AW'(src_eff);
               end
            end
         end else begin
            column_in = column_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pixels_ff <= RESET_LINE_PIXELS;
         src_lines_ff   <= RESET_SRC_LINES;
         dst_lines_ff   <= RESET_DST_LINES;
         column_ff      <= '0;
         src_row_ff     <= '0;
         out_row_ff     <= '0;
         acc_ff         <= '0;
         brd_ff         <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_LINE_PIXELS: line_pixels_ff <= csr_data;
               REG_SRC_LINES:   src_lines_ff   <= csr_data;
               REG_DST_LINES:   dst_lines_ff   <= csr_data;
               default: ;
            endcase
         end
         column_ff  <= column_in;
         src_row_ff <= src_row_in;
         out_row_ff <= out_row_in;
         acc_ff     <= acc_in;
         brd_ff     <= brd_in;
      end
   end

   a_out_row_bound: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= dst_eff)
      else $error("output row count exceeds the output line count");

   a_src_row_bound: assert property (@(posedge clock) disable iff (reset)
      src_row_ff < src_eff)
      else $error("source row beyond the source line count");

   a_acc_floor: assert property (@(posedge clock) disable iff (reset)
      acc_ff >= brd_ff)
      else $error("next kept row lies behind the current source row");

endmodule

>>> hdl/yuyv_to_rgb565_vertical_scaler.sv
// Top level of the YUYV to RGB565 converter with nearest-neighbour vertical scaler.
// Instantiates yvs_row_ctrl, yvs_chroma and two yvs_pixel_lane lanes; uses yvs_pkg.
//
// The block takes one YUYV macro-pixel word per clock while rsp_tready does not hold the
// pipeline, and returns one RGB565 pixel-pair word for every input word that falls on a
// kept source row; words on dropped rows give nothing. A result is registered first in
// the chroma stage, which holds the chroma terms, then in the output register, which holds
// the packed pixels of both lanes.
// Both stages advance whenever the stage ahead is empty or drained, so req_tready follows
// rsp_tready through them and a stalled result does not block the input while the
// chroma stage is free. Configuration writes are always taken and restart the frame.
module yuyv_to_rgb565_vertical_scaler #(
   parameter int MAX_LINE_PIXELS = 2048,
   parameter int MAX_LINES       = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // luma_first, chroma_blue, luma_second, chroma_red (8 bits each, lowest first)
   input  logic [31:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rgb_first [15:0], rgb_second [31:16]
   output logic [31:0]                   rsp_tdata,
   output logic                          rsp_tlast,
   // second_valid [0], frame_last [1]
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [yvs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [yvs_pkg::CFG_W-1:0]     csr_data
);
   import yvs_pkg::*;

   row_ctrl_type     ctrl;
   chroma_terms_type terms;
   logic             req_fire;
   logic             s1_en;
   logic             out_en;

   logic             s1_valid_ff;
   logic [7:0]       s1_luma0_ff;
   logic [7:0]       s1_luma1_ff;
   chroma_terms_type s1_terms_ff;
   row_ctrl_type     s1_ctrl_ff;

   logic [15:0]      lane_rgb0;
   logic [15:0]      lane_rgb1;

   logic             out_valid_ff;
   logic [31:0]      out_data_ff;
   logic             out_last_ff;
   logic [1:0]       out_user_ff;

   assign csr_ready  = 1'b1;
   assign out_en     = !out_valid_ff || rsp_tready;
   assign s1_en      = !s1_valid_ff || out_en;
   assign req_tready = s1_en;
   assign req_fire   = req_tvalid && req_tready;

   yvs_row_ctrl #(
      .MAX_LINE_PIXELS(MAX_LINE_PIXELS),
      .MAX_LINES      (MAX_LINES)
   ) u_row_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .advance  (req_fire),
      .ctrl     (ctrl)
   );

   yvs_chroma u_chroma (
      .chroma_blue(req_tdata[15:8]),
      .chroma_red (req_tdata[31:24]),
      .terms      (terms)
   );

   yvs_pixel_lane u_lane0 (
      .luma (s1_luma0_ff),
      .terms(s1_terms_ff),
      .rgb  (lane_rgb0)
   );

   yvs_pixel_lane u_lane1 (
      .luma (s1_luma1_ff),
      .terms(s1_terms_ff),
      .rgb  (lane_rgb1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_fire && ctrl.kept;
         end
         if (out_en) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_luma0_ff <= req_tdata[7:0];
         s1_luma1_ff <= req_tdata[23:16];
         s1_terms_ff <= terms;
         s1_ctrl_ff  <= ctrl;
      end
      // The merge stage joins both lanes and the row flags into one result word.
      if (out_en) begin
         out_data_ff <= {lane_rgb1, lane_rgb0};
         out_last_ff <= s1_ctrl_ff.line_last;
         out_user_ff <= {s1_ctrl_ff.frame_last, s1_ctrl_ff.second_valid};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

   a_frame_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("frame end marked on a word that does not end a line");

   a_second_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("missing second pixel on a word that does not end a line");

endmodule
